FILE: src/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and codes for the debounce and press classifier block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    // apb register map
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam logic [1:0]  REG_EDGE_SELECT  = 2'd0;
    localparam logic [1:0]  REG_SAMPLE_INTVL = 2'd1;
    localparam logic [1:0]  REG_LONG_PRESS   = 2'd2;

    // register reset values
    localparam logic [1:0]  EDGE_SELECT_RST  = 2'd0;
    localparam logic [15:0] SAMPLE_INTVL_RST = 16'd0;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;

    // edge select bits
    localparam int unsigned SEL_RISE_BIT = 0;
    localparam int unsigned SEL_FALL_BIT = 1;

    // level codes
    localparam logic [1:0] CODE_LOW  = 2'd0;
    localparam logic [1:0] CODE_HIGH = 2'd1;
    localparam logic [1:0] CODE_ROSE = 2'd2;
    localparam logic [1:0] CODE_FELL = 2'd3;

    // press events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]  edge_select;
        logic [15:0] sample_interval_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic        raw_sample;
        logic [31:0] time_ms;
        logic        ack_rise;
        logic        ack_fall;
    } item_t;

    typedef struct packed {
        logic [1:0] level_code;
        logic       edge_pulse;
        logic       code_changed;
        logic [1:0] press_event;
        logic       rise_seen;
        logic       fall_seen;
    } result_t;

endpackage

`default_nettype wire

FILE: src/bdpc_apb_regs.sv
// ----------------------------------------------------------------------------
// bdpc_apb_regs
// APB configuration registers: edge select, sample interval, long press limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bdpc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bdpc_pkg::PDATA_W-1:0]    pwdata,
    output logic      [bdpc_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    output bdpc_pkg::cfg_t                       cfg
);
    import bdpc_pkg::*;

    logic [1:0]  edge_select_reg;
    logic [15:0] sample_intvl_reg;
    logic [15:0] long_press_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_select_reg  <= EDGE_SELECT_RST;
            sample_intvl_reg <= SAMPLE_INTVL_RST;
            long_press_reg   <= LONG_PRESS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EDGE_SELECT:  edge_select_reg  <= pwdata[1:0];
                REG_SAMPLE_INTVL: sample_intvl_reg <= pwdata[15:0];
                REG_LONG_PRESS:   long_press_reg   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_EDGE_SELECT:  prdata = {30'd0, edge_select_reg};
            REG_SAMPLE_INTVL: prdata = {16'd0, sample_intvl_reg};
            REG_LONG_PRESS:   prdata = {16'd0, long_press_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.edge_select        = edge_select_reg;
    assign cfg.sample_interval_ms = sample_intvl_reg;
    assign cfg.long_press_ms      = long_press_reg;

endmodule

`default_nettype wire

FILE: src/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce state, edge report and press timing; one word per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  bdpc_pkg::cfg_t       cfg,
    input  wire logic            step,
    input  bdpc_pkg::item_t      item,
    output bdpc_pkg::result_t    res
);
    import bdpc_pkg::*;

    logic        last_raw_reg,      last_raw_next;
    logic        stable_reg,        stable_next;
    logic [1:0]  pending_reg,       pending_next;
    logic [1:0]  reported_reg,      reported_next;
    logic [31:0] last_accept_reg,   last_accept_next;
    logic        rise_flag_reg,     rise_flag_next;
    logic        fall_flag_reg,     fall_flag_next;
    logic [31:0] press_start_reg,   press_start_next;
    logic        long_rep_reg,      long_rep_next;

    logic        intvl_zero;
    logic [31:0] elapsed;
    logic        take;
    logic [1:0]  code;
    logic        rise_set;
    logic        fall_set;
    logic [31:0] held;
    logic        under_limit;

    // sample acceptance
    assign intvl_zero = (cfg.sample_interval_ms == 16'd0);
    assign elapsed    = item.time_ms - last_accept_reg;
    assign take       = intvl_zero || (elapsed >= {16'd0, cfg.sample_interval_ms});

    // press duration
    assign held        = item.time_ms - press_start_reg;
    assign under_limit = (held < {16'd0, cfg.long_press_ms});

    // next state and result
    always_comb
    begin
        last_raw_next    = last_raw_reg;
        stable_next      = stable_reg;
        code             = pending_reg;
        rise_set         = 1'b0;
        fall_set         = 1'b0;
        last_accept_next = last_accept_reg;
        press_start_next = press_start_reg;
        long_rep_next    = long_rep_reg;
        res.press_event  = EV_NONE;

        if (take)
        begin
            if (!intvl_zero)
            begin
                last_accept_next = item.time_ms;
            end
            if (item.raw_sample == last_raw_reg)
            begin
                if (item.raw_sample != stable_reg)
                begin
                    stable_next = item.raw_sample;
                    code        = item.raw_sample ? CODE_ROSE : CODE_FELL;
                    rise_set    = item.raw_sample;
                    fall_set    = !item.raw_sample;
                end
                else
                begin
                    code = item.raw_sample ? CODE_HIGH : CODE_LOW;
                end
            end
            last_raw_next = item.raw_sample;
        end

        reported_next = code;
        unique case (code)
            CODE_ROSE: pending_next = CODE_HIGH;
            CODE_FELL: pending_next = CODE_LOW;
            default:   pending_next = code;
        endcase

        // press classification
        if (code == CODE_FELL)
        begin
            press_start_next = item.time_ms;
            long_rep_next    = 1'b0;
        end
        if (code == CODE_ROSE && under_limit)
        begin
            res.press_event = EV_SHORT;
        end
        if (code == CODE_LOW && !long_rep_reg && !under_limit)
        begin
            long_rep_next   = 1'b1;
            res.press_event = EV_LONG;
        end

        // sticky flags: report from the edge onward, clear on ack
        res.rise_seen  = rise_flag_reg || rise_set;
        res.fall_seen  = fall_flag_reg || fall_set;
        rise_flag_next = res.rise_seen && !item.ack_rise;
        fall_flag_next = res.fall_seen && !item.ack_fall;

        res.level_code   = code;
        res.code_changed = (reported_reg != code);
        res.edge_pulse   = ((code == CODE_ROSE) && cfg.edge_select[SEL_RISE_BIT]) ||
                           ((code == CODE_FELL) && cfg.edge_select[SEL_FALL_BIT]);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            pending_reg     <= CODE_LOW;
            reported_reg    <= CODE_LOW;
            last_accept_reg <= '0;
            rise_flag_reg   <= 1'b0;
            fall_flag_reg   <= 1'b0;
            press_start_reg <= '0;
            long_rep_reg    <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            pending_reg     <= pending_next;
            reported_reg    <= reported_next;
            last_accept_reg <= last_accept_next;
            rise_flag_reg   <= rise_flag_next;
            fall_flag_reg   <= fall_flag_next;
            press_start_reg <= press_start_next;
            long_rep_reg    <= long_rep_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/button_debounce_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Switch debouncer with edge report and short/long press classifier.
// ----------------------------------------------------------------------------
// A word accepted into the input register moves on to the result register
// once the result register is free, and appears on the output from there.
// Throughput: one word per cycle while the output is not stalled; the input
// register feeds the state logic and the result register in a single pass.
// in_ready stays high while the result register is empty or being taken.
// Reset (rst_n low, asynchronous) clears all state and config to defaults.
`default_nettype none

module button_debounce_press_classifier_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // apb configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bdpc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bdpc_pkg::PDATA_W-1:0]    pwdata,
    output logic      [bdpc_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            raw_sample,
    input  wire logic [31:0]                     time_ms,
    input  wire logic                            ack_rise,
    input  wire logic                            ack_fall,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           level_code,
    output logic                                 edge_pulse,
    output logic                                 code_changed,
    output logic [1:0]                           press_event,
    output logic                                 rise_seen,
    output logic                                 fall_seen
);
    import bdpc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    step;

    bdpc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign out_free = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.raw_sample <= raw_sample;
            item_reg.time_ms    <= time_ms;
            item_reg.ack_rise   <= ack_rise;
            item_reg.ack_fall   <= ack_fall;
        end
    end

    bdpc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (item_reg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign level_code   = res_reg.level_code;
    assign edge_pulse   = res_reg.edge_pulse;
    assign code_changed = res_reg.code_changed;
    assign press_event  = res_reg.press_event;
    assign rise_seen    = res_reg.rise_seen;
    assign fall_seen    = res_reg.fall_seen;

endmodule

`default_nettype wire

FILE: src/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks on the result channel of the press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] level_code,
    input wire logic       edge_pulse,
    input wire logic [1:0] press_event
);
    import bdpc_pkg::*;

    // a short press is only reported on the rising edge that ends it
    a_short_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_event == EV_SHORT |-> level_code == CODE_ROSE)
        else $error("short press without rising edge");

    // a long press is only reported while the level is settled low
    a_long_on_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_event == EV_LONG |-> level_code == CODE_LOW)
        else $error("long press while not held low");

    // pulse only goes out on a reported edge
    a_pulse_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_pulse |-> level_code == CODE_ROSE || level_code == CODE_FELL)
        else $error("edge pulse without edge code");

    // a taken rising edge code is never followed by a second rising edge code
    a_edge_settles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && level_code == CODE_ROSE ##1 out_valid
        |-> level_code != CODE_ROSE)
        else $error("rising edge reported twice in a row");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_code  (level_code),
    .edge_pulse  (edge_pulse),
    .press_event (press_event)
);

`default_nettype wire

FILE: test/button_debounce_press_classifier_top_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_tb
// Self-checking bench for the switch debouncer and press classifier. A
// tracker class keeps its own copy of the debounce, edge-report and press
// timing state, predicts one result word per accepted input word, and checks
// results in order. Stimulus is directed corner cases at reset settings, then
// random press and release sequences with bounce across several register
// settings, with random idling on both channels and long output hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier_top_tb;

    import bdpc_pkg::*;

    // predictor and in-order result checker
    class debounce_tracker;
        logic [1:0]  edge_sel;
        logic [15:0] intvl;
        logic [15:0] long_ms;
        logic        last_raw;
        logic        stable_lvl;
        logic [1:0]  next_code;
        logic [1:0]  shown_code;
        logic [31:0] last_accept;
        logic [31:0] press_t0;
        logic        rise_flag;
        logic        fall_flag;
        logic        long_done;
        result_t     pending_results[$];
        int unsigned fail_count;

        function new();
            edge_sel    = EDGE_SELECT_RST;
            intvl       = SAMPLE_INTVL_RST;
            long_ms     = LONG_PRESS_RST;
            last_raw    = 1'b0;
            stable_lvl  = 1'b0;
            next_code   = CODE_LOW;
            shown_code  = CODE_LOW;
            last_accept = '0;
            press_t0    = '0;
            rise_flag   = 1'b0;
            fall_flag   = 1'b0;
            long_done   = 1'b0;
            fail_count  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_EDGE_SELECT:  edge_sel = val[1:0];
                REG_SAMPLE_INTVL: intvl    = val[15:0];
                REG_LONG_PRESS:   long_ms  = val[15:0];
                default: ;
            endcase
        endfunction

        function void report_error(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        // work out the result word for one accepted input word
        function void classify_word(item_t w);
            result_t     r;
            logic [31:0] since_accept;
            logic [31:0] held;

            r = '0;
            since_accept = w.time_ms - last_accept;
            // sample acceptance and two-in-a-row debounce
            if (intvl == 16'd0 || since_accept >= {16'd0, intvl})
            begin
                if (intvl != 16'd0)
                    last_accept = w.time_ms;
                if (w.raw_sample == last_raw)
                begin
                    if (w.raw_sample != stable_lvl)
                    begin
                        stable_lvl = w.raw_sample;
                        if (w.raw_sample)
                        begin
                            next_code = CODE_ROSE;
                            rise_flag = 1'b1;
                        end
                        else
                        begin
                            next_code = CODE_FELL;
                            fall_flag = 1'b1;
                        end
                    end
                    else
                        next_code = w.raw_sample ? CODE_HIGH : CODE_LOW;
                end
                last_raw = w.raw_sample;
            end

            // one-shot code report and edge pulse
            r.code_changed = (shown_code != next_code);
            shown_code     = next_code;
            r.level_code   = shown_code;
            r.edge_pulse   = (shown_code == CODE_ROSE && edge_sel[SEL_RISE_BIT]) ||
                             (shown_code == CODE_FELL && edge_sel[SEL_FALL_BIT]);
            if (next_code == CODE_ROSE)
                next_code = CODE_HIGH;
            if (next_code == CODE_FELL)
                next_code = CODE_LOW;

            // press timing, switch is active low
            if (shown_code == CODE_FELL)
            begin
                press_t0  = w.time_ms;
                long_done = 1'b0;
            end
            held = w.time_ms - press_t0;
            r.press_event = EV_NONE;
            if (shown_code == CODE_ROSE && held < {16'd0, long_ms})
                r.press_event = EV_SHORT;
            if (r.press_event == EV_NONE && shown_code == CODE_LOW && !long_done &&
                held >= {16'd0, long_ms})
            begin
                long_done     = 1'b1;
                r.press_event = EV_LONG;
            end

            // sticky flags shown before this word's acknowledge
            r.rise_seen = rise_flag;
            r.fall_seen = fall_flag;
            if (w.ack_rise)
                rise_flag = 1'b0;
            if (w.ack_fall)
                fall_flag = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;

            if (pending_results.size() == 0)
            begin
                report_error("result word with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            if (got.level_code !== want.level_code || got.edge_pulse !== want.edge_pulse ||
                got.code_changed !== want.code_changed ||
                got.press_event !== want.press_event ||
                got.rise_seen !== want.rise_seen || got.fall_seen !== want.fall_seen)
                report_error($sformatf({"exp code=%0d pulse=%0d chg=%0d ev=%0d rs=%0d fs=%0d",
                    " got code=%0d pulse=%0d chg=%0d ev=%0d rs=%0d fs=%0d"},
                    want.level_code, want.edge_pulse, want.code_changed, want.press_event,
                    want.rise_seen, want.fall_seen, got.level_code, got.edge_pulse,
                    got.code_changed, got.press_event, got.rise_seen, got.fall_seen));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic                 raw_sample;
    logic [31:0]          time_ms;
    logic                 ack_rise;
    logic                 ack_fall;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           level_code;
    logic                 edge_pulse;
    logic                 code_changed;
    logic [1:0]           press_event;
    logic                 rise_seen;
    logic                 fall_seen;

    debounce_tracker tracker = new();
    logic [31:0]     cur_time;
    int unsigned     words_sent;
    logic            rx_holding;

    button_debounce_press_classifier_top dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // register write followed by a read back
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] mask;

        mask = (idx == REG_EDGE_SELECT) ? 32'h3 : 32'hFFFF;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        tracker.set_reg(idx, val);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) !== (val & mask))
            tracker.report_error($sformatf("register %0d read %0h, wrote %0h", idx, rd, val));
    endtask

    // offer one input word after a random gap, wait for acceptance
    task automatic push_word(input logic raw, input logic [31:0] t,
                             input logic ar, input logic af);
        item_t       w;
        int unsigned gap;

        w.raw_sample = raw;
        w.time_ms    = t;
        w.ack_rise   = ar;
        w.ack_fall   = af;
        gap = (rx_holding || ((words_sent / 64) % 4) == 3) ? 0 : $urandom_range(0, 18);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        raw_sample <= w.raw_sample;
        time_ms    <= w.time_ms;
        ack_rise   <= w.ack_rise;
        ack_fall   <= w.ack_fall;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.classify_word(w);
        words_sent++;
    endtask

    // advance time by a random step and offer a word with random acknowledges
    task automatic push_step(input logic raw, input int unsigned span);
        cur_time += ($urandom_range(0, 39) == 0) ? $urandom_range(0, 200000)
                                                 : $urandom_range(0, span);
        push_word(raw, cur_time, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    endtask

    // one press: bounce, hold low, bounce, hold high
    task automatic press_cycle();
        logic [31:0] t0;
        int unsigned span;
        int unsigned lim;
        int unsigned hold;
        int unsigned n;

        span = tracker.intvl;
        span = span + 2;
        lim  = tracker.long_ms;
        repeat ($urandom_range(0, 3)) push_step($urandom_range(0, 1), span);
        hold = $urandom_range(0, 2 * lim + 8);
        t0   = cur_time;
        n    = 0;
        do
        begin
            push_step(1'b0, hold / 4 + span);
            n++;
        end
        while ((cur_time - t0) < hold && n < 24);
        repeat ($urandom_range(0, 3)) push_step($urandom_range(0, 1), span);
        repeat ($urandom_range(2, 6)) push_step(1'b1, span);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls plus long hold-offs
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        result_t     got;

        out_ready  = 1'b0;
        rx_holding = 1'b0;
        taken      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken == 400 || taken == 1300)
            begin
                rx_holding = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                rx_holding = 1'b0;
            end
            stall = (((taken / 50) % 3) == 2) ? 0 : $urandom_range(0, 18);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            got.level_code   = level_code;
            got.edge_pulse   = edge_pulse;
            got.code_changed = code_changed;
            got.press_event  = press_event;
            got.rise_seen    = rise_seen;
            got.fall_seen    = fall_seen;
            tracker.check_result(got);
            taken++;
        end
    end

    // reset, directed words, then random phases
    initial
    begin
        logic [1:0]  sel_tab[10]  = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1};
        logic [15:0] intv_tab[10] = '{16'd0, 16'd1, 16'd0, 16'd3, 16'd65535,
                                      16'd7, 16'd0, 16'd2, 16'd65535, 16'd5};
        logic [15:0] long_tab[10] = '{16'd20, 16'd0, 16'd65535, 16'd100, 16'd50,
                                      16'd1, 16'd30, 16'd200, 16'd15, 16'd1000};
        logic [31:0] t;
        int unsigned target;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        raw_sample = 1'b0;
        time_ms    = '0;
        ack_rise   = 1'b0;
        ack_fall   = 1'b0;
        words_sent = 0;
        cur_time   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // low after reset reaches the default limit, then a late release
        push_word(1'b0, 32'd0, 1'b0, 1'b0);
        push_word(1'b0, 32'd999, 1'b0, 1'b0);
        push_word(1'b0, 32'd1000, 1'b0, 1'b0);
        push_word(1'b0, 32'd1001, 1'b0, 1'b0);
        push_word(1'b1, 32'd1002, 1'b1, 1'b1);
        push_word(1'b1, 32'd1003, 1'b0, 1'b0);
        push_word(1'b1, 32'd1004, 1'b1, 1'b0);
        // quick press, short press with both acknowledges on the edge
        push_word(1'b0, 32'd1005, 1'b0, 1'b0);
        push_word(1'b0, 32'd1006, 1'b0, 1'b0);
        push_word(1'b1, 32'd1010, 1'b0, 1'b0);
        push_word(1'b1, 32'd1011, 1'b1, 1'b1);
        // press across the time wrap, long press exactly at the limit
        push_word(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
        push_word(1'b0, 32'hFFFF_FFF1, 1'b0, 1'b1);
        push_word(1'b0, 32'h0000_03D8, 1'b0, 1'b0);
        push_word(1'b0, 32'h0000_03D9, 1'b0, 1'b0);
        push_word(1'b0, 32'h0000_03DA, 1'b0, 1'b1);
        // time stepping backwards, release and bounce
        push_word(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_word(1'b1, 32'h0000_0000, 1'b0, 1'b0);
        push_word(1'b0, 32'd5, 1'b1, 1'b0);
        push_word(1'b1, 32'd6, 1'b0, 1'b0);
        push_word(1'b1, 32'd7, 1'b0, 1'b0);
        cur_time = 32'd7;
        drain();

        for (int p = 0; p < 10; p++)
        begin
            apb_write(REG_EDGE_SELECT, {30'd0, sel_tab[p]});
            apb_write(REG_SAMPLE_INTVL, {16'd0, intv_tab[p]});
            apb_write(REG_LONG_PRESS, {16'd0, long_tab[p]});
            if (p == 4 || p == 8)
                cur_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            target = words_sent + 193;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // noise word at an arbitrary time
                    t = $urandom();
                    if ($urandom_range(0, 1))
                        cur_time = t;
                    push_word($urandom_range(0, 1), t, $urandom_range(0, 1),
                              $urandom_range(0, 1));
                end
                else
                    press_cycle();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (tracker.fail_count == 0 && tracker.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/bdpc_pkg.sv
src/bdpc_apb_regs.sv
src/bdpc_core.sv
src/button_debounce_press_classifier_top.sv
src/bdpc_checker.sv
test/button_debounce_press_classifier_top_tb.sv
